// ----- hdl/obj_fip_pkg.sv -----
package obj_fip_pkg;

    localparam int CH_W   = 8;
    localparam int BND_W  = 25;
    localparam int IDX_W  = 24;
    localparam int ACC_W  = 33;
    localparam int PROD_W = ACC_W + 4;

    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    // largest value a part may hold, and the clamp value once it overflows
    localparam logic [ACC_W-1:0] LIMIT32   = 33'h0_FFFF_FFFF;
    localparam logic [ACC_W-1:0] OVERFLOWN = 33'h1_0000_0000;

    // which part of the element is being read
    typedef enum logic [3:0] {
        STAGE_VERTEX   = 4'b0001,
        STAGE_TEXCOORD = 4'b0010,
        STAGE_NORMAL   = 4'b0100,
        STAGE_FAILED   = 4'b1000
    } t_stage;

    // number being collected for the current part
    typedef struct packed {
        logic             negative;
        logic             digits_seen;
        logic             too_large;
        logic [ACC_W-1:0] acc;
    } t_num;

    typedef struct packed {
        t_stage           stage;
        t_num             num;
        logic             number_ended;
        logic             part_empty;
        logic [IDX_W-1:0] held_vertex;
        logic [IDX_W-1:0] held_texcoord;
        logic             texcoord_seen;
        logic             element_complete;
        logic             skip_rest;
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_idx;
        logic [IDX_W-1:0] texcoord_idx;
        logic [IDX_W-1:0] normal_idx;
        logic             has_texcoord;
        logic             bad_format;
        logic             last;
    } t_result;

endpackage

// ----- hdl/obj_fip_index.sv -----
module obj_fip_index (
    input  obj_fip_pkg::t_num               i_num,
    input  logic [obj_fip_pkg::BND_W-1:0]   i_bound,
    output logic                            o_ok,
    output logic [obj_fip_pkg::IDX_W-1:0]   o_idx
);
    import obj_fip_pkg::*;

    logic [ACC_W-1:0] bound_w;
    logic [ACC_W-1:0] acc_m1;
    logic [ACC_W-1:0] from_end;
    logic             base_ok;
    logic             pos_ok;
    logic             neg_ok;

    assign bound_w  = {{(ACC_W-BND_W){1'b0}}, i_bound};
    assign acc_m1   = i_num.acc - ACC_W'(1);
    assign from_end = bound_w - i_num.acc;
    assign base_ok  = i_num.digits_seen && !i_num.too_large && (i_num.acc != '0);
    assign pos_ok   = acc_m1 < bound_w;
    // acc is nonzero here, so bound - acc is always below bound
    assign neg_ok   = i_num.acc <= bound_w;

    always_comb begin
        if (i_num.negative) begin
            o_ok  = base_ok && neg_ok;
            o_idx = from_end[IDX_W-1:0];
        end else begin
            o_ok  = base_ok && pos_ok;
            o_idx = acc_m1[IDX_W-1:0];
        end
    end

endmodule

// ----- hdl/obj_fip_parse.sv -----
module obj_fip_parse (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [obj_fip_pkg::CH_W-1:0]    i_ch,
    input  logic                            i_line_end,
    input  logic [obj_fip_pkg::BND_W-1:0]   i_bound,
    output logic                            o_emit,
    output obj_fip_pkg::t_result            o_result
);
    import obj_fip_pkg::*;

    function automatic t_state part_clear(input t_state s);
        t_state r;
        r                  = s;
        r.num              = '0;
        r.number_ended     = 1'b0;
        r.part_empty       = 1'b1;
        return r;
    endfunction

    function automatic t_state elem_clear(input t_state s);
        t_state r;
        r                  = part_clear(s);
        r.stage            = STAGE_VERTEX;
        r.held_vertex      = '0;
        r.held_texcoord    = '0;
        r.texcoord_seen    = 1'b0;
        r.element_complete = 1'b0;
        return r;
    endfunction

    function automatic logic is_idle(input t_state s);
        return s.skip_rest || s.element_complete || (s.stage == STAGE_FAILED);
    endfunction

    t_state              r_st;
    t_state              n_st;
    t_state              fed;
    t_state              pre;
    t_state              post;
    logic                is_sep;
    logic                is_space;
    logic                is_digit;
    logic                is_sign;
    logic [CH_W-1:0]     dval;
    logic [PROD_W-1:0]   prod;
    logic                idx_ok;
    logic [IDX_W-1:0]    idx;
    logic                good;

    assign is_space = (i_ch == CH_SPACE);
    assign is_sep   = is_space || (i_ch == CH_SLASH);
    assign is_digit = i_ch inside {[CH_ZERO:CH_NINE]};
    assign is_sign  = (i_ch == CH_PLUS) || (i_ch == CH_MINUS);
    assign dval     = i_ch - CH_ZERO;
    // acc * 10 + digit as shift-add
    assign prod     = ({{(PROD_W-ACC_W){1'b0}}, r_st.num.acc} << 3)
                    + ({{(PROD_W-ACC_W){1'b0}}, r_st.num.acc} << 1)
                    + {{(PROD_W-CH_W){1'b0}}, dval};

    // character feed
    always_comb begin
        fed = r_st;
        if (!is_idle(r_st)) begin
            fed.part_empty = 1'b0;
            if (!r_st.number_ended) begin
                if (is_digit) begin
                    if (prod > {{(PROD_W-ACC_W){1'b0}}, LIMIT32}) begin
                        fed.num.too_large = 1'b1;
                        fed.num.acc       = OVERFLOWN;
                    end else begin
                        fed.num.acc       = prod[ACC_W-1:0];
                    end
                    fed.num.digits_seen = 1'b1;
                end else if (r_st.part_empty && is_sign) begin
                    fed.num.negative = (i_ch == CH_MINUS);
                end else begin
                    fed.number_ended = 1'b1;
                end
            end
        end
    end

    // a separator closes the part as it stands; a line end on any other
    // character closes it after that character has been fed
    assign pre = is_sep ? r_st : fed;

    obj_fip_index u_index (
        .i_num   (pre.num),
        .i_bound (i_bound),
        .o_ok    (idx_ok),
        .o_idx   (idx)
    );

    always_comb begin
        post     = pre;
        o_emit   = 1'b0;
        o_result = '0;
        good     = 1'b0;

        // part close
        if ((is_sep || i_line_end) && !is_idle(pre)) begin
            post = part_clear(pre);
            if (pre.part_empty) begin
                if (pre.stage == STAGE_TEXCOORD) begin
                    post.texcoord_seen = 1'b0;
                    post.stage         = STAGE_NORMAL;
                end else begin
                    post.stage         = STAGE_FAILED;
                end
            end else if (!idx_ok) begin
                post.stage = STAGE_FAILED;
            end else begin
                case (pre.stage)
                    STAGE_VERTEX: begin
                        post.held_vertex = idx;
                        post.stage       = STAGE_TEXCOORD;
                    end
                    STAGE_TEXCOORD: begin
                        post.held_texcoord = idx;
                        post.texcoord_seen = 1'b1;
                        post.stage         = STAGE_NORMAL;
                    end
                    STAGE_NORMAL: begin
                        post.num.acc          = {{(ACC_W-IDX_W){1'b0}}, idx};
                        post.element_complete = 1'b1;
                    end
                    default: begin
                        post.stage = STAGE_FAILED;
                    end
                endcase
            end
        end

        // element close
        if ((is_space || i_line_end) && !post.skip_rest) begin
            good                  = post.element_complete;
            o_emit                = 1'b1;
            o_result.vertex_idx   = good ? post.held_vertex : '0;
            o_result.texcoord_idx = (good && post.texcoord_seen) ? post.held_texcoord : '0;
            o_result.normal_idx   = good ? post.num.acc[IDX_W-1:0] : '0;
            o_result.has_texcoord = good && post.texcoord_seen;
            o_result.bad_format   = !good;
            o_result.last         = i_line_end;
            // space in the line-end slot leaves an empty final element
            if (is_space && i_line_end) begin
                o_result            = '0;
                o_result.bad_format = 1'b1;
                o_result.last       = 1'b1;
            end
            post = elem_clear(post);
            if (!good) begin
                post.skip_rest = 1'b1;
            end
        end

        if (i_line_end) begin
            post           = elem_clear(post);
            post.skip_rest = 1'b0;
        end

        n_st = i_step ? post : r_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= elem_clear('0);
        end else begin
            r_st <= n_st;
        end
    end

endmodule

// ----- hdl/obj_face_index_parser.sv -----
// OBJ face index parser.
// Input channel: one character word per cycle (i_ch, i_line_end, i_vertex_total),
// accepted when i_in_valid is high and o_in_stall is low. i_line_end marks the
// last character of a face line; the line end also closes the open element.
// Output channel: one word per finished vertex/texcoord/normal element,
// taken when o_out_valid is high and i_out_stall is low. o_bad_format flags
// a malformed or out-of-range element, after which the line is skipped up to
// its end. o_last marks the word produced on the line-end character.
// Timing: a word accepted into the input register is parsed when the parse step
// runs, and its result is then held in the result register for the output.
// Throughput: one character per cycle unless stalled; the parse step is one
// register stage (input register -> per-character update -> result register).
// Stall: while the result register is full and i_out_stall is high, the parse
// step holds and o_in_stall rises once the input register is occupied.
// Reset (synchronous, i_rst_n low): parser state returns to the start of an
// element, both registers empty.
module obj_face_index_parser #(
    parameter longint unsigned MAX_VERTICES = 16777216
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [obj_fip_pkg::CH_W-1:0]    i_ch,
    input  logic                            i_line_end,
    input  logic [obj_fip_pkg::BND_W-1:0]   i_vertex_total,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [obj_fip_pkg::IDX_W-1:0]   o_vertex_idx,
    output logic [obj_fip_pkg::IDX_W-1:0]   o_texcoord_idx,
    output logic [obj_fip_pkg::IDX_W-1:0]   o_normal_idx,
    output logic                            o_has_texcoord,
    output logic                            o_bad_format,
    output logic                            o_last
);
    import obj_fip_pkg::*;

    // input register
    logic               r_s1_valid;
    logic               n_s1_valid;
    logic [CH_W-1:0]    r_s1_ch;
    logic               r_s1_le;
    logic [BND_W-1:0]   r_s1_vt;

    // result register
    logic               r_out_valid;
    logic               n_out_valid;
    t_result            r_out;

    logic               out_free;
    logic               step;
    logic               accept_in;
    logic [BND_W-1:0]   bound;
    logic               emit;
    t_result            result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept_in  = i_in_valid && !o_in_stall;

    // vertex count is clamped to the configured maximum
    assign bound = ({39'd0, r_s1_vt} > MAX_VERTICES) ? MAX_VERTICES[BND_W-1:0] : r_s1_vt;

    obj_fip_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_ch       (r_s1_ch),
        .i_line_end (r_s1_le),
        .i_bound    (bound),
        .o_emit     (emit),
        .o_result   (result)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept_in) begin
            n_s1_valid = 1'b1;
        end else if (step) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_ch <= i_ch;
            r_s1_le <= i_line_end;
            r_s1_vt <= i_vertex_total;
        end
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_vertex_idx   = r_out.vertex_idx;
    assign o_texcoord_idx = r_out.texcoord_idx;
    assign o_normal_idx   = r_out.normal_idx;
    assign o_has_texcoord = r_out.has_texcoord;
    assign o_bad_format   = r_out.bad_format;
    assign o_last         = r_out.last;

endmodule
